// ===== src/mfr_pkg.sv =====
// Shared constants and codes for the message frame receiver.
package mfr_pkg;

  // Largest payload length accepted; longer frames are dropped
  localparam int unsigned MAX_PAYLOAD  = 256;
  // Number of little-endian length bytes after the sequence byte
  localparam int unsigned LENGTH_BYTES = 4;

  // Field widths
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned LEN_W     = 8 * LENGTH_BYTES;
  localparam int unsigned LEN_IDX_W = (LENGTH_BYTES > 1) ? $clog2(LENGTH_BYTES) : 1;
  localparam int unsigned POS_W     = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD + 1) : 1;
  localparam int unsigned CNT_W     = (POS_W > LEN_IDX_W) ? POS_W : LEN_IDX_W;
  localparam int unsigned STATUS_W  = 2;

  // Configuration register map
  localparam int unsigned CFG_ADDR_W  = 3;
  localparam int unsigned CFG_DATA_W  = 32;
  localparam logic        REG_MAGIC_FIRST  = 1'b0;
  localparam logic        REG_MAGIC_SECOND = 1'b1;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_PAYLOAD   = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_TOO_LONG  = 2'd2
  } status_t;

endpackage

// ===== src/message_frame_receiver_core.sv =====
// Message frame receiver: byte parser with stream input, stream output and APB registers.
//
// Parses a byte stream into frames: a two-byte magic word (either byte order,
// the order is reported as order_swapped), a type byte, a sequence byte, a
// little-endian payload length, then the payload. Each payload byte becomes
// one output transaction with tlast on the final byte. A zero-length frame
// gives one empty-status transaction and a length above the maximum gives one
// too-long-status transaction; both carry tlast and a zero data byte. Header
// bytes give no output. Every input byte is handled in the cycle it is
// accepted, so the block takes one byte per clock; the only limit is the
// single output register, which accepts a new byte whenever it is empty or is
// being drained in the same cycle. Write the magic registers only while idle.
module message_frame_receiver_core (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  // Result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [7:0] data_byte, [15:8] msg_type,
                                  // [23:16] seq_number, [24] order_swapped, [31:25] zero
  output logic [1:0]  out_tuser,  // [1:0] status
  output logic        out_tlast,  // last_of_message
  // Configuration port
  input  logic                                    cfg_psel,
  input  logic                                    cfg_penable,
  input  logic                                    cfg_pwrite,
  input  logic [mfr_pkg::CFG_ADDR_W-1:0]          cfg_paddr,
  input  logic [mfr_pkg::CFG_DATA_W-1:0]          cfg_pwdata,
  output logic [mfr_pkg::CFG_DATA_W-1:0]          cfg_prdata,
  output logic                                    cfg_pready
);

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_MAGIC2 = 3'd1,
    PH_TYPE   = 3'd2,
    PH_SEQ    = 3'd3,
    PH_LEN    = 3'd4,
    PH_DATA   = 3'd5
  } phase_t;

  // Registers
  logic [mfr_pkg::BYTE_W-1:0] magic_first_r;
  logic [mfr_pkg::BYTE_W-1:0] magic_second_r;

  phase_t                      phase_r, phase_nxt;
  logic                        swapped_r, swapped_nxt;
  logic [mfr_pkg::BYTE_W-1:0]  type_r, type_nxt;
  logic [mfr_pkg::BYTE_W-1:0]  seq_r, seq_nxt;
  logic [mfr_pkg::LEN_W-1:0]   length_r, length_nxt;
  logic [mfr_pkg::CNT_W-1:0]   pos_r, pos_nxt;

  logic                        out_valid_r, out_valid_nxt;
  mfr_pkg::status_t            out_status_r, out_status_nxt;
  logic [mfr_pkg::BYTE_W-1:0]  out_data_r, out_data_nxt;
  logic [mfr_pkg::BYTE_W-1:0]  out_type_r, out_type_nxt;
  logic [mfr_pkg::BYTE_W-1:0]  out_seq_r, out_seq_nxt;
  logic                        out_swapped_r, out_swapped_nxt;
  logic                        out_last_r, out_last_nxt;

  logic                        in_accept;
  logic                        cfg_write;
  logic [mfr_pkg::BYTE_W-1:0]  rx_byte;
  logic [mfr_pkg::BYTE_W-1:0]  magic_expect;
  logic [mfr_pkg::CNT_W-1:0]   pos_inc;
  logic                        data_last;

  // Handshakes
  assign in_tready  = !out_valid_r || out_tready;
  assign in_accept  = in_tvalid && in_tready;
  assign cfg_pready = 1'b1;
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign rx_byte    = in_tdata;

  // Register read data
  always_comb begin
    case (cfg_paddr[2])
      mfr_pkg::REG_MAGIC_FIRST:  cfg_prdata = mfr_pkg::CFG_DATA_W'(magic_first_r);
      mfr_pkg::REG_MAGIC_SECOND: cfg_prdata = mfr_pkg::CFG_DATA_W'(magic_second_r);
      default:                   cfg_prdata = '0;
    endcase
  end

  assign magic_expect = swapped_r ? magic_first_r : magic_second_r;
  assign pos_inc      = pos_r + 1'b1;
  assign data_last    = 32'(pos_inc) >= 32'(length_r);

  // Parse one byte and build the next result
  always_comb begin
    phase_nxt       = phase_r;
    swapped_nxt     = swapped_r;
    type_nxt        = type_r;
    seq_nxt         = seq_r;
    length_nxt      = length_r;
    pos_nxt         = pos_r;
    out_valid_nxt   = out_valid_r && !out_tready;
    out_status_nxt  = out_status_r;
    out_data_nxt    = out_data_r;
    out_type_nxt    = out_type_r;
    out_seq_nxt     = out_seq_r;
    out_swapped_nxt = out_swapped_r;
    out_last_nxt    = out_last_r;

    if (in_accept) begin
      // Header fields travel with every result
      out_type_nxt    = type_r;
      out_seq_nxt     = seq_r;
      out_swapped_nxt = swapped_r;
      out_data_nxt    = '0;

      case (phase_r)
        PH_IDLE: begin
          if (rx_byte == magic_first_r) begin
            swapped_nxt = 1'b0;
            phase_nxt   = PH_MAGIC2;
          end else if (rx_byte == magic_second_r) begin
            swapped_nxt = 1'b1;
            phase_nxt   = PH_MAGIC2;
          end
        end
        PH_MAGIC2: begin
          phase_nxt = (rx_byte == magic_expect) ? PH_TYPE : PH_IDLE;
        end
        PH_TYPE: begin
          type_nxt  = rx_byte;
          phase_nxt = PH_SEQ;
        end
        PH_SEQ: begin
          seq_nxt    = rx_byte;
          pos_nxt    = '0;
          length_nxt = '0;
          phase_nxt  = PH_LEN;
        end
        PH_LEN: begin
          // Place the byte little-endian, check the limit after the last one
          length_nxt[pos_r[mfr_pkg::LEN_IDX_W-1:0] * 8 +: 8] = rx_byte;
          pos_nxt = pos_inc;
          if (32'(pos_inc) >= 32'(mfr_pkg::LENGTH_BYTES)) begin
            pos_nxt = '0;
            if (length_nxt == '0) begin
              phase_nxt      = PH_IDLE;
              out_valid_nxt  = 1'b1;
              out_status_nxt = mfr_pkg::ST_EMPTY;
              out_last_nxt   = 1'b1;
            end else if (32'(length_nxt) > 32'(mfr_pkg::MAX_PAYLOAD)) begin
              phase_nxt      = PH_IDLE;
              out_valid_nxt  = 1'b1;
              out_status_nxt = mfr_pkg::ST_TOO_LONG;
              out_last_nxt   = 1'b1;
            end else begin
              phase_nxt = PH_DATA;
            end
          end
        end
        PH_DATA: begin
          pos_nxt        = pos_inc;
          out_valid_nxt  = 1'b1;
          out_status_nxt = mfr_pkg::ST_PAYLOAD;
          out_data_nxt   = rx_byte;
          out_last_nxt   = data_last;
          if (data_last) begin
            phase_nxt = PH_IDLE;
            pos_nxt   = '0;
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end
  end

  // Hold state, configuration and the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_first_r  <= '0;
      magic_second_r <= '0;
      phase_r        <= PH_IDLE;
      swapped_r      <= 1'b0;
      type_r         <= '0;
      seq_r          <= '0;
      length_r       <= '0;
      pos_r          <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_paddr[2])
          mfr_pkg::REG_MAGIC_FIRST:  magic_first_r  <= cfg_pwdata[mfr_pkg::BYTE_W-1:0];
          mfr_pkg::REG_MAGIC_SECOND: magic_second_r <= cfg_pwdata[mfr_pkg::BYTE_W-1:0];
          default: ;
        endcase
      end
      phase_r     <= phase_nxt;
      swapped_r   <= swapped_nxt;
      type_r      <= type_nxt;
      seq_r       <= seq_nxt;
      length_r    <= length_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_status_r  <= out_status_nxt;
    out_data_r    <= out_data_nxt;
    out_type_r    <= out_type_nxt;
    out_seq_r     <= out_seq_nxt;
    out_swapped_r <= out_swapped_nxt;
    out_last_r    <= out_last_nxt;
  end

  // Drive the result stream
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_swapped_r, out_seq_r, out_type_r, out_data_r};
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;

endmodule
